FILE: sv/sm83_lsu_pkg.sv
package sm83_lsu_pkg;

   // bus request codes
   typedef logic [2:0] bus_op_type;
   localparam bus_op_type BUS_NONE = 3'd0;
   localparam bus_op_type BUS_RD8  = 3'd1;
   localparam bus_op_type BUS_RD16 = 3'd2;
   localparam bus_op_type BUS_WR8  = 3'd3;
   localparam bus_op_type BUS_WR16 = 3'd4;

   // result status codes
   typedef logic [1:0] status_type;
   localparam status_type ST_OK   = 2'd0;
   localparam status_type ST_BAD  = 2'd1;
   localparam status_type ST_BUSY = 2'd2;

   // outstanding read kind
   typedef logic [1:0] pend_type;
   localparam pend_type PEND_NONE = 2'd0;
   localparam pend_type PEND_BYTE = 2'd1;
   localparam pend_type PEND_WORD = 2'd2;

   // register file order B,C,D,E,H,L,F,A
   typedef logic [2:0] reg_idx_type;
   localparam reg_idx_type IDX_B = 3'd0;
   localparam reg_idx_type IDX_C = 3'd1;
   localparam reg_idx_type IDX_D = 3'd2;
   localparam reg_idx_type IDX_E = 3'd3;
   localparam reg_idx_type IDX_H = 3'd4;
   localparam reg_idx_type IDX_L = 3'd5;
   localparam reg_idx_type IDX_F = 3'd6;
   localparam reg_idx_type IDX_A = 3'd7;

   typedef logic [1:0] pair_type;
   localparam pair_type PAIR_AF_SP = 2'd3;

   localparam logic [7:0]  HIGH_PAGE = 8'hFF;
   localparam logic [15:0] SP_STEP   = 16'd2;

   // instruction families
   typedef logic [4:0] family_type;
   localparam family_type FAM_LD_A_BC    = 5'd0;
   localparam family_type FAM_LD_A_HC    = 5'd1;
   localparam family_type FAM_LD_A_DE    = 5'd2;
   localparam family_type FAM_LD_A_HLS   = 5'd3;
   localparam family_type FAM_LD_A_N16   = 5'd4;
   localparam family_type FAM_LD_A_HN8   = 5'd5;
   localparam family_type FAM_ST_BC_A    = 5'd6;
   localparam family_type FAM_ST_HC_A    = 5'd7;
   localparam family_type FAM_ST_DE_A    = 5'd8;
   localparam family_type FAM_ST_HLS_A   = 5'd9;
   localparam family_type FAM_ST_HL_N8   = 5'd10;
   localparam family_type FAM_ST_HL_R8   = 5'd11;
   localparam family_type FAM_ST_N16_A   = 5'd12;
   localparam family_type FAM_ST_N16_SP  = 5'd13;
   localparam family_type FAM_ST_HN8_A   = 5'd14;
   localparam family_type FAM_LD_R16_N16 = 5'd15;
   localparam family_type FAM_LD_R8_HL   = 5'd16;
   localparam family_type FAM_LD_R8_N8   = 5'd17;
   localparam family_type FAM_LD_R8_R8   = 5'd18;
   localparam family_type FAM_LD_SP_HL   = 5'd19;
   localparam family_type FAM_POP        = 5'd20;
   localparam family_type FAM_PUSH       = 5'd21;

   // address source
   typedef logic [3:0] addr_sel_type;
   localparam addr_sel_type ASEL_NONE    = 4'd0;
   localparam addr_sel_type ASEL_BC      = 4'd1;
   localparam addr_sel_type ASEL_DE      = 4'd2;
   localparam addr_sel_type ASEL_HL      = 4'd3;
   localparam addr_sel_type ASEL_IMM     = 4'd4;
   localparam addr_sel_type ASEL_HIGH_C  = 4'd5;
   localparam addr_sel_type ASEL_HIGH_N8 = 4'd6;
   localparam addr_sel_type ASEL_SP      = 4'd7;
   localparam addr_sel_type ASEL_SP_DEC  = 4'd8;

   // write data source
   typedef logic [2:0] wdata_sel_type;
   localparam wdata_sel_type WSEL_NONE = 3'd0;
   localparam wdata_sel_type WSEL_A    = 3'd1;
   localparam wdata_sel_type WSEL_N8   = 3'd2;
   localparam wdata_sel_type WSEL_SRC  = 3'd3;
   localparam wdata_sel_type WSEL_SP   = 3'd4;
   localparam wdata_sel_type WSEL_PAIR = 3'd5;

   // register side effect
   typedef logic [2:0] effect_type;
   localparam effect_type EFF_NONE    = 3'd0;
   localparam effect_type EFF_HL_STEP = 3'd1;
   localparam effect_type EFF_LD16    = 3'd2;
   localparam effect_type EFF_LD8_IMM = 3'd3;
   localparam effect_type EFF_LD8_REG = 3'd4;
   localparam effect_type EFF_SP_HL   = 3'd5;
   localparam effect_type EFF_POP     = 3'd6;
   localparam effect_type EFF_PUSH    = 3'd7;

   // classified beat passed from front to back
   typedef struct packed {
      logic          is_resp;
      logic          bad;
      bus_op_type    bus_op;
      addr_sel_type  asel;
      wdata_sel_type wsel;
      effect_type    effect;
      logic          rd_to_dst;
      logic          hl_dec;
      reg_idx_type   dst;
      reg_idx_type   src;
      pair_type      pair;
      logic [15:0]   immediate;
      logic [15:0]   read_data;
   } cmd_type;

endpackage

FILE: sv/sm83_lsu_req_if.sv
interface sm83_lsu_req_if import sm83_lsu_pkg::*; ();
   logic        valid;
   logic        ready;
   logic        kind;
   family_type  family;
   logic [7:0]  opcode;
   logic [15:0] immediate;
   logic [15:0] read_data;

   modport source (output valid, kind, family, opcode, immediate, read_data, input ready);
   modport sink   (input valid, kind, family, opcode, immediate, read_data, output ready);
endinterface

FILE: sv/sm83_lsu_rsp_if.sv
interface sm83_lsu_rsp_if import sm83_lsu_pkg::*; ();
   logic        valid;
   logic        ready;
   bus_op_type  bus_op;
   logic [15:0] bus_address;
   logic [15:0] bus_write_data;
   status_type  status;
   logic [15:0] af_value;
   logic [15:0] bc_value;
   logic [15:0] de_value;
   logic [15:0] hl_value;
   logic [15:0] sp_value;

   modport source (output valid, bus_op, bus_address, bus_write_data, status,
                   af_value, bc_value, de_value, hl_value, sp_value, input ready);
   modport sink   (input valid, bus_op, bus_address, bus_write_data, status,
                   af_value, bc_value, de_value, hl_value, sp_value, output ready);
endinterface

FILE: sv/sm83_lsu_front.sv
module sm83_lsu_front import sm83_lsu_pkg::*; (
   sm83_lsu_req_if.sink req_chan,
   input  logic         q_full,
   output logic         q_push,
   output cmd_type      q_cmd
);

   assign req_chan.ready = !q_full;
   assign q_push         = req_chan.valid && !q_full;

   // classify the beat into address, data and effect selects
   always_comb begin
      q_cmd           = '0;
      q_cmd.is_resp   = req_chan.kind;
      q_cmd.hl_dec    = req_chan.opcode[4];
      q_cmd.dst       = req_chan.opcode[5:3];
      q_cmd.src       = req_chan.opcode[2:0];
      q_cmd.pair      = req_chan.opcode[5:4];
      q_cmd.immediate = req_chan.immediate;
      q_cmd.read_data = req_chan.read_data;
      q_cmd.bus_op    = BUS_NONE;
      q_cmd.asel      = ASEL_NONE;
      q_cmd.wsel      = WSEL_NONE;
      q_cmd.effect    = EFF_NONE;
      unique case (req_chan.family)
         FAM_LD_A_BC: begin
            q_cmd.bus_op = BUS_RD8; q_cmd.asel = ASEL_BC;
         end
         FAM_LD_A_HC: begin
            q_cmd.bus_op = BUS_RD8; q_cmd.asel = ASEL_HIGH_C;
         end
         FAM_LD_A_DE: begin
            q_cmd.bus_op = BUS_RD8; q_cmd.asel = ASEL_DE;
         end
         FAM_LD_A_HLS: begin
            q_cmd.bus_op = BUS_RD8; q_cmd.asel = ASEL_HL; q_cmd.effect = EFF_HL_STEP;
         end
         FAM_LD_A_N16: begin
            q_cmd.bus_op = BUS_RD8; q_cmd.asel = ASEL_IMM;
         end
         FAM_LD_A_HN8: begin
            q_cmd.bus_op = BUS_RD8; q_cmd.asel = ASEL_HIGH_N8;
         end
         FAM_ST_BC_A: begin
            q_cmd.bus_op = BUS_WR8; q_cmd.asel = ASEL_BC; q_cmd.wsel = WSEL_A;
         end
         FAM_ST_HC_A: begin
            q_cmd.bus_op = BUS_WR8; q_cmd.asel = ASEL_HIGH_C; q_cmd.wsel = WSEL_A;
         end
         FAM_ST_DE_A: begin
            q_cmd.bus_op = BUS_WR8; q_cmd.asel = ASEL_DE; q_cmd.wsel = WSEL_A;
         end
         FAM_ST_HLS_A: begin
            q_cmd.bus_op = BUS_WR8; q_cmd.asel = ASEL_HL; q_cmd.wsel = WSEL_A;
            q_cmd.effect = EFF_HL_STEP;
         end
         FAM_ST_HL_N8: begin
            q_cmd.bus_op = BUS_WR8; q_cmd.asel = ASEL_HL; q_cmd.wsel = WSEL_N8;
         end
         FAM_ST_HL_R8: begin
            q_cmd.bus_op = BUS_WR8; q_cmd.asel = ASEL_HL; q_cmd.wsel = WSEL_SRC;
         end
         FAM_ST_N16_A: begin
            q_cmd.bus_op = BUS_WR8; q_cmd.asel = ASEL_IMM; q_cmd.wsel = WSEL_A;
         end
         FAM_ST_N16_SP: begin
            q_cmd.bus_op = BUS_WR16; q_cmd.asel = ASEL_IMM; q_cmd.wsel = WSEL_SP;
         end
         FAM_ST_HN8_A: begin
            q_cmd.bus_op = BUS_WR8; q_cmd.asel = ASEL_HIGH_N8; q_cmd.wsel = WSEL_A;
         end
         FAM_LD_R16_N16: q_cmd.effect = EFF_LD16;
         FAM_LD_R8_HL: begin
            q_cmd.bus_op = BUS_RD8; q_cmd.asel = ASEL_HL; q_cmd.rd_to_dst = 1'b1;
         end
         FAM_LD_R8_N8: q_cmd.effect = EFF_LD8_IMM;
         FAM_LD_R8_R8: begin
            q_cmd.effect = EFF_LD8_REG;
            q_cmd.bad    = (req_chan.opcode[5:3] == req_chan.opcode[2:0]);
         end
         FAM_LD_SP_HL: q_cmd.effect = EFF_SP_HL;
         FAM_POP: begin
            q_cmd.bus_op = BUS_RD16; q_cmd.asel = ASEL_SP; q_cmd.effect = EFF_POP;
         end
         FAM_PUSH: begin
            q_cmd.bus_op = BUS_WR16; q_cmd.asel = ASEL_SP_DEC; q_cmd.wsel = WSEL_PAIR;
            q_cmd.effect = EFF_PUSH;
         end
         default: q_cmd.bad = 1'b1;
      endcase
   end

endmodule

FILE: sv/sm83_lsu_queue.sv
module sm83_lsu_queue import sm83_lsu_pkg::*; #(
   parameter int Depth = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    not_empty,
   output cmd_type pop_data
);

   localparam int PtrW = $clog2(Depth);
   localparam int CntW = $clog2(Depth + 1);

   cmd_type         slot_ff [Depth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] cnt_ff, cnt_in;

   assign full      = (cnt_ff == CntW'(Depth));
   assign not_empty = (cnt_ff != '0);
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full && !pop))
      else $error("queue written while full");

endmodule

FILE: sv/sm83_lsu_back.sv
module sm83_lsu_back import sm83_lsu_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           q_valid,
   input  cmd_type        q_cmd,
   output logic           q_pop,
   sm83_lsu_rsp_if.source rsp_chan
);

   logic [7:0]  rf_ff [8];
   logic [7:0]  rf_in [8];
   logic [15:0] sp_ff, sp_in;
   pend_type    pend_ff, pend_in;
   reg_idx_type pdest_ff, pdest_in;

   logic        rsp_valid_ff;
   bus_op_type  op_ff, op_in;
   logic [15:0] addr_ff, addr_in;
   logic [15:0] wdata_ff, wdata_in;
   status_type  st_ff, st_in;
   logic [15:0] af_ff, bc_ff, de_ff, hl_ff, spv_ff;

   logic        advance;
   logic [15:0] hl, hl_next, pair_val;

   // advance when the output register is empty or being drained
   assign advance = !rsp_valid_ff || rsp_chan.ready;
   assign q_pop   = q_valid && advance;

   assign hl       = {rf_ff[IDX_H], rf_ff[IDX_L]};
   assign hl_next  = q_cmd.hl_dec ? hl - 16'd1 : hl + 16'd1;
   assign pair_val = (q_cmd.pair == PAIR_AF_SP) ? {rf_ff[IDX_A], rf_ff[IDX_F]}
                   : {rf_ff[{q_cmd.pair, 1'b0}], rf_ff[{q_cmd.pair, 1'b1}]};

   always_comb begin
      rf_in    = rf_ff;
      sp_in    = sp_ff;
      pend_in  = pend_ff;
      pdest_in = pdest_ff;
      op_in    = BUS_NONE;
      addr_in  = '0;
      wdata_in = '0;
      st_in    = ST_OK;
      if (q_cmd.is_resp) begin
         case (pend_ff)
            PEND_BYTE: rf_in[pdest_ff] = q_cmd.read_data[7:0];
            PEND_WORD: begin
               if (pdest_ff[1:0] == PAIR_AF_SP) begin
                  rf_in[IDX_A] = q_cmd.read_data[15:8];
                  rf_in[IDX_F] = q_cmd.read_data[7:0];
               end else begin
                  rf_in[{pdest_ff[1:0], 1'b0}] = q_cmd.read_data[15:8];
                  rf_in[{pdest_ff[1:0], 1'b1}] = q_cmd.read_data[7:0];
               end
            end
            default: ;
         endcase
         pend_in  = PEND_NONE;
         pdest_in = IDX_B;
      end else if (pend_ff != PEND_NONE) begin
         st_in = ST_BUSY;
      end else if (q_cmd.bad) begin
         st_in = ST_BAD;
      end else begin
         op_in = q_cmd.bus_op;
         case (q_cmd.asel)
            ASEL_BC:      addr_in = {rf_ff[IDX_B], rf_ff[IDX_C]};
            ASEL_DE:      addr_in = {rf_ff[IDX_D], rf_ff[IDX_E]};
            ASEL_HL:      addr_in = hl;
            ASEL_IMM:     addr_in = q_cmd.immediate;
            ASEL_HIGH_C:  addr_in = {HIGH_PAGE, rf_ff[IDX_C]};
            ASEL_HIGH_N8: addr_in = {HIGH_PAGE, q_cmd.immediate[7:0]};
            ASEL_SP:      addr_in = sp_ff;
            ASEL_SP_DEC:  addr_in = sp_ff - SP_STEP;
            default:      addr_in = '0;
         endcase
         case (q_cmd.wsel)
            WSEL_A:    wdata_in = {8'h00, rf_ff[IDX_A]};
            WSEL_N8:   wdata_in = {8'h00, q_cmd.immediate[7:0]};
            WSEL_SRC:  wdata_in = {8'h00, rf_ff[q_cmd.src]};
            WSEL_SP:   wdata_in = sp_ff;
            WSEL_PAIR: wdata_in = pair_val;
            default:   wdata_in = '0;
         endcase
         case (q_cmd.effect)
            EFF_HL_STEP: begin
               rf_in[IDX_H] = hl_next[15:8];
               rf_in[IDX_L] = hl_next[7:0];
            end
            EFF_LD16: begin
               if (q_cmd.pair == PAIR_AF_SP) begin
                  sp_in = q_cmd.immediate;
               end else begin
                  rf_in[{q_cmd.pair, 1'b0}] = q_cmd.immediate[15:8];
                  rf_in[{q_cmd.pair, 1'b1}] = q_cmd.immediate[7:0];
               end
            end
            EFF_LD8_IMM: rf_in[q_cmd.dst] = q_cmd.immediate[7:0];
            EFF_LD8_REG: rf_in[q_cmd.dst] = rf_ff[q_cmd.src];
            EFF_SP_HL:   sp_in = hl;
            EFF_POP:     sp_in = sp_ff + SP_STEP;
            EFF_PUSH:    sp_in = sp_ff - SP_STEP;
            default: ;
         endcase
         if (q_cmd.bus_op == BUS_RD8) begin
            pend_in  = PEND_BYTE;
            pdest_in = q_cmd.rd_to_dst ? q_cmd.dst : IDX_A;
         end else if (q_cmd.bus_op == BUS_RD16) begin
            pend_in  = PEND_WORD;
            pdest_in = {1'b0, q_cmd.pair};
         end
      end
      // F keeps its low nibble clear on every write
      rf_in[IDX_F][3:0] = 4'h0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            rf_ff[i] <= '0;
         end
         sp_ff        <= '0;
         pend_ff      <= PEND_NONE;
         pdest_ff     <= IDX_B;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (q_pop) begin
            rf_ff    <= rf_in;
            sp_ff    <= sp_in;
            pend_ff  <= pend_in;
            pdest_ff <= pdest_in;
         end
         if (advance) begin
            rsp_valid_ff <= q_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         op_ff    <= op_in;
         addr_ff  <= addr_in;
         wdata_ff <= wdata_in;
         st_ff    <= st_in;
         af_ff    <= {rf_in[IDX_A], rf_in[IDX_F]};
         bc_ff    <= {rf_in[IDX_B], rf_in[IDX_C]};
         de_ff    <= {rf_in[IDX_D], rf_in[IDX_E]};
         hl_ff    <= {rf_in[IDX_H], rf_in[IDX_L]};
         spv_ff   <= sp_in;
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.bus_op         = op_ff;
   assign rsp_chan.bus_address    = addr_ff;
   assign rsp_chan.bus_write_data = wdata_ff;
   assign rsp_chan.status         = st_ff;
   assign rsp_chan.af_value       = af_ff;
   assign rsp_chan.bc_value       = bc_ff;
   assign rsp_chan.de_value       = de_ff;
   assign rsp_chan.hl_value       = hl_ff;
   assign rsp_chan.sp_value       = spv_ff;

   a_flag_nibble: assert property (@(posedge clock) disable iff (reset)
      rf_ff[IDX_F][3:0] == 4'h0)
      else $error("F low nibble set");

   a_busy_no_bus: assert property (@(posedge clock) disable iff (reset)
      q_pop && !q_cmd.is_resp && pend_ff != PEND_NONE
      |=> st_ff == ST_BUSY && op_ff == BUS_NONE && rsp_valid_ff)
      else $error("instruction during pending read not reported busy");

   a_resp_clears: assert property (@(posedge clock) disable iff (reset)
      q_pop && q_cmd.is_resp |=> pend_ff == PEND_NONE)
      else $error("read response left a read pending");

   a_read_pends: assert property (@(posedge clock) disable iff (reset)
      q_pop && !q_cmd.is_resp && pend_ff == PEND_NONE && !q_cmd.bad
      && (q_cmd.bus_op == BUS_RD8 || q_cmd.bus_op == BUS_RD16)
      |=> pend_ff != PEND_NONE)
      else $error("issued read not recorded as pending");

endmodule

FILE: sv/sm83_load_store_unit_top.sv
// Channel   Dir  Handshake      Beat carries
// req_chan  in   valid / ready  kind, family, opcode, immediate, read_data
// rsp_chan  out  valid / ready  bus_op, bus_address, bus_write_data, status,
//                               af_value, bc_value, de_value, hl_value, sp_value
//
// One beat per cycle sustained while rsp_chan.ready holds; each request's response is
// registered in the cycle after it leaves the queue; an accepted request is first written to a queue slot.
// The register file, SP and pending-read state update together in the back end when a beat is popped.
// Reset is synchronous: registers, SP and pending state clear at once, no clearing pass.
// A stalled rsp_chan holds the output register; the queue absorbs up to QueueDepth
// requests before req_chan.ready drops.
module sm83_load_store_unit_top import sm83_lsu_pkg::*; #(
   parameter int QueueDepth = 2
) (
   input  logic           clock,
   input  logic           reset,
   sm83_lsu_req_if.sink   req_chan,
   sm83_lsu_rsp_if.source rsp_chan
);

   // front end to queue
   logic    q_push;
   logic    q_full;
   cmd_type q_in;

   // queue to back end
   logic    q_pop;
   logic    q_valid;
   cmd_type q_out;

   // accept and classify each beat
   sm83_lsu_front u_front (
      .req_chan (req_chan),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_cmd    (q_in)
   );

   // hold classified beats so either side may stall on its own
   sm83_lsu_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_valid),
      .pop_data  (q_out)
   );

   // execute against the register file and drive the registered response
   sm83_lsu_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_valid),
      .q_cmd    (q_out),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule
